@@ design/segmented_record_list_engine_core_macros.svh @@
// Assertion macros for the segmented record list engine.
`ifndef SEGMENTED_RECORD_LIST_ENGINE_CORE_MACROS_SVH
`define SEGMENTED_RECORD_LIST_ENGINE_CORE_MACROS_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define SRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Assert that an expression holds at every edge out of reset.
`define SRLE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`endif

@@ design/srle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_pkg
// Commands, status codes and shared types of the segmented record list engine.
// ----------------------------------------------------------------------------
package srle_pkg;
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_NEXT    = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_DELETE  = 3'd4;
  localparam logic [2:0] CMD_COMPACT = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_POS  = 2'd3;

  localparam logic [0:0] REG_RANGE_SIZE = 1'd0;
endpackage

@@ design/srle_entry_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_entry_store
// Entry memory: locator and deleted mark per slot, one port, registered read.
// ----------------------------------------------------------------------------
module srle_entry_store #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [63:0]   wlocator,
  input  logic          wdeleted,
  output logic [63:0]   rlocator,
  output logic          rdeleted
);
  logic [64:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= {wdeleted, wlocator};
    end
    {rdeleted, rlocator} <= mem[addr];
  end
endmodule

@@ design/segmented_record_list_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_record_list_engine_core
// Command-driven list of 64-bit locators held in fill-counted segments.
// ----------------------------------------------------------------------------
// A command item is taken when start is high and busy is low; busy then stays
// high until the single result item is shown on the result ports for one
// cycle with done high. The receiver cannot stall, so done is never held.
// One sequencer walks the entry memory through its single port, one slot at
// a time with a registered read. Read and delete pass through a read wait,
// a result step and the done state; a rejected item (invalid locator, bad
// position, next at end, unused code) goes straight to the done state. Add
// scans segment fill counts one at a time, writes, then ends in the done
// state. Start and next visit each slot through seek, wait and check states
// and skip a segment in a seek step; compact reads each stored slot of a
// segment it packs the same way and passes a segment without deletions.
// The entry memory needs no clearing pass: only slots below a fill count are
// ever read. The segment size register sits at APB byte address 0.
// ----------------------------------------------------------------------------
module segmented_record_list_engine_core #(
  parameter int MAX_RANGES      = 16,
  parameter int MAX_RANGE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [63:0] locator,
  input  logic [3:0]  range_index,
  input  logic [5:0]  slot_index,
  input  logic        at_end,
  output logic        done,
  output logic [1:0]  status,
  output logic        found,
  output logic [3:0]  result_range,
  output logic [5:0]  result_slot,
  output logic [63:0] result_locator
);
  import srle_pkg::*;

  localparam int RW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int SW = (MAX_RANGE_SLOTS > 1) ? $clog2(MAX_RANGE_SLOTS) : 1;
  localparam int FW = $clog2(MAX_RANGE_SLOTS + 1);
  localparam int OW = $clog2(MAX_RANGES + 1);
  localparam int AW = RW + SW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ASCAN = 4'd1;
  localparam logic [3:0] S_SEEK  = 4'd2;
  localparam logic [3:0] S_SWAIT = 4'd3;
  localparam logic [3:0] S_SCHK  = 4'd4;
  localparam logic [3:0] S_RWAIT = 4'd5;
  localparam logic [3:0] S_RDONE = 4'd6;
  localparam logic [3:0] S_CSEG  = 4'd7;
  localparam logic [3:0] S_CRD   = 4'd8;
  localparam logic [3:0] S_CWAIT = 4'd9;
  localparam logic [3:0] S_CCHK  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]  state;
  logic [6:0]  seg_size;
  logic [FW-1:0] fill [0:MAX_RANGES-1];
  logic [MAX_RANGES-1:0] has_del;
  logic [OW-1:0] segs_open;
  // Working registers of the sequencer.
  logic [2:0]  op;
  logic [63:0] loc_q;
  logic [RW:0] r;
  logic [FW:0] s;
  logic [FW:0] w;
  // Memory port.
  logic          we;
  logic [AW-1:0] addr;
  logic [63:0]   wloc, rloc;
  logic          wdel, rdel;
  logic [FW-1:0] size_use;
  logic [RW-1:0] r_ix;

  srle_entry_store #(.AW(AW)) u_store (
    .clk(clk), .we(we), .addr(addr), .wlocator(wloc), .wdeleted(wdel),
    .rlocator(rloc), .rdeleted(rdel)
  );

  assign pready = 1'b1;
  assign prdata = {25'd0, seg_size};
  assign busy   = (state != S_IDLE);
  assign r_ix   = r[RW-1:0];

  always_comb begin
    if (seg_size == 7'd0) size_use = FW'(1);
    else if (32'(seg_size) > MAX_RANGE_SLOTS) size_use = FW'(MAX_RANGE_SLOTS);
    else size_use = FW'(seg_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seg_size   <= 7'd64;
      has_del    <= '0;
      segs_open  <= OW'(1);
      done       <= 1'b0;
      we         <= 1'b0;
      for (int i = 0; i < MAX_RANGES; i++) fill[i] <= '0;
    end else begin
      done <= 1'b0;
      we   <= 1'b0;
      if (psel && penable && pwrite && paddr == REG_RANGE_SIZE) seg_size <= pwdata[6:0];
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= cmd; loc_q <= locator;
            status <= ST_OK; found <= 1'b0; result_range <= '0;
            result_slot <= '0; result_locator <= '0;
            r <= '0; s <= '0; w <= '0;
            case (cmd)
              CMD_ADD: begin
                if (locator == 64'd0) begin
                  status <= ST_INVALID; state <= S_DONE;
                end else state <= S_ASCAN;
              end
              CMD_START: state <= S_SEEK;
              CMD_NEXT: begin
                if (at_end) state <= S_DONE;
                else if (32'(range_index) >= 32'(segs_open)) begin
                  status <= ST_BAD_POS; state <= S_DONE;
                end else begin
                  r <= (RW+1)'(range_index);
                  s <= (FW+1)'(slot_index) + (FW+1)'(1);
                  state <= S_SEEK;
                end
              end
              CMD_READ, CMD_DELETE: begin
                if (at_end || 32'(range_index) >= 32'(segs_open) ||
                    32'(slot_index) >= 32'(fill[RW'(range_index)])) begin
                  status <= ST_BAD_POS; state <= S_DONE;
                end else begin
                  r <= (RW+1)'(range_index); s <= (FW+1)'(slot_index);
                  addr <= AW'({RW'(range_index), SW'(slot_index)});
                  state <= S_RWAIT;
                end
              end
              CMD_COMPACT: state <= S_CSEG;
              default: state <= S_DONE;
            endcase
          end
        end
        S_ASCAN: begin
          if (32'(r) >= 32'(segs_open)) begin
            if (32'(segs_open) >= MAX_RANGES) begin
              status <= ST_FULL; state <= S_DONE;
            end else begin
              segs_open <= segs_open + OW'(1);
              fill[r_ix] <= FW'(1); has_del[r_ix] <= 1'b0;
              we <= 1'b1; addr <= AW'({r_ix, SW'(0)}); wloc <= loc_q; wdel <= 1'b0;
              found <= 1'b1; result_range <= 4'(r_ix); result_slot <= '0;
              state <= S_DONE;
            end
          end else if (fill[r_ix] < size_use) begin
            fill[r_ix] <= fill[r_ix] + FW'(1);
            we <= 1'b1; addr <= AW'({r_ix, SW'(fill[r_ix])});
            wloc <= loc_q; wdel <= 1'b0;
            found <= 1'b1; result_range <= 4'(r_ix); result_slot <= 6'(fill[r_ix]);
            state <= S_DONE;
          end else r <= r + (RW+1)'(1);
        end
        S_SEEK: begin
          if (32'(r) >= 32'(segs_open)) state <= S_DONE;
          else if (s >= (FW+1)'(fill[r_ix])) begin
            r <= r + (RW+1)'(1); s <= '0;
          end else begin
            addr <= AW'({r_ix, SW'(s)}); state <= S_SWAIT;
          end
        end
        S_SWAIT: state <= S_SCHK;
        S_SCHK: begin
          if (!rdel) begin
            found <= 1'b1; result_range <= 4'(r_ix); result_slot <= 6'(s);
            result_locator <= rloc; state <= S_DONE;
          end else begin
            s <= s + (FW+1)'(1); state <= S_SEEK;
          end
        end
        S_RWAIT: state <= S_RDONE;
        S_RDONE: begin
          found <= 1'b1; result_range <= 4'(r_ix); result_slot <= 6'(s);
          result_locator <= rloc;
          if (op == CMD_DELETE) begin
            we <= 1'b1; wloc <= rloc; wdel <= 1'b1; has_del[r_ix] <= 1'b1;
          end
          state <= S_DONE;
        end
        S_CSEG: begin
          if (32'(r) >= 32'(segs_open)) state <= S_DONE;
          else if (!has_del[r_ix]) r <= r + (RW+1)'(1);
          else begin
            s <= '0; w <= '0; state <= S_CRD;
          end
        end
        S_CRD: begin
          if (s >= (FW+1)'(fill[r_ix])) begin
            fill[r_ix] <= FW'(w); has_del[r_ix] <= 1'b0;
            r <= r + (RW+1)'(1); state <= S_CSEG;
          end else begin
            addr <= AW'({r_ix, SW'(s)}); state <= S_CWAIT;
          end
        end
        S_CWAIT: state <= S_CCHK;
        S_CCHK: begin
          if (!rdel) begin
            we <= 1'b1; addr <= AW'({r_ix, SW'(w)}); wloc <= rloc; wdel <= 1'b0;
            w <= w + (FW+1)'(1);
          end
          s <= s + (FW+1)'(1); state <= S_CRD;
        end
        S_DONE: begin
          done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ design/srle_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_checker
// Port-level checks of the command handshake and result fields.
// ----------------------------------------------------------------------------
`include "segmented_record_list_engine_core_macros.svh"
module srle_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic       found,
  input logic       pready
);
  import srle_pkg::*;
  // An accepted item makes the block busy.
  `SRLE_ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy, "not busy after item")
  // A result is shown only once the work on its item has ended.
  `SRLE_ASSERT_ALWAYS(a_idle_with_done, clk, rst, !(done && busy), "busy during result")
  // A result is only shown when an item was at work just before it.
  `SRLE_ASSERT_NEXT(a_done_from_busy, clk, rst, !busy, !done, "result without item")
  // A found entry always comes with status ok.
  `SRLE_ASSERT_ALWAYS(a_found_ok, clk, rst, !(done && found) || status == ST_OK, "found with bad status")
  `SRLE_ASSERT_ALWAYS(a_pready, clk, rst, pready, "pready low")
endmodule

bind segmented_record_list_engine_core srle_checker u_srle_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .found(found), .pready(pready)
);

@@ tb/segmented_record_list_engine_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_record_list_engine_core_tb
// Self-checking bench for the segmented record list engine.
// ----------------------------------------------------------------------------
// Command items go in through the start/busy handshake. A behavioral copy of
// the locator list computes the result of every accepted item. A monitor
// compares each done strobe field by field with the oldest pending
// expectation. The run starts with directed corner cases and a full-list
// test, then random command mixes under several sizes, clamped extremes too.
// ----------------------------------------------------------------------------
module segmented_record_list_engine_core_tb;
  import srle_pkg::*;

  localparam int NUM_SEGS   = 16;
  localparam int SEG_SLOTS  = 64;
  localparam int CYCLE_LIMIT = 30000000;

  // One result item as the block reports it.
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [3:0]  rng;
    logic [5:0]  slot;
    logic [63:0] loc;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  cmd = '0;
  logic [63:0] locator = '0;
  logic [3:0]  range_index = '0;
  logic [5:0]  slot_index = '0;
  logic        at_end = 1'b0;
  logic        done;
  logic [1:0]  status;
  logic        found;
  logic [3:0]  result_range;
  logic [5:0]  result_slot;
  logic [63:0] result_locator;

  segmented_record_list_engine_core dut (.*);

  // The clock runs with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the list: locators, deleted marks and segment bookkeeping.
  logic [63:0] shadow_loc [NUM_SEGS][SEG_SLOTS];
  bit          shadow_del [NUM_SEGS][SEG_SLOTS];
  int          seg_fill [NUM_SEGS];
  bit          seg_dirty [NUM_SEGS];
  int          segs_open;
  logic [6:0]  seg_size_reg;

  list_result_t pending_results[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  found_hits = 0;
  int  full_hits = 0;
  int  bad_pos_hits = 0;
  int  cmd_counts [8];
  bit  gaps_enabled = 1'b1;
  longint unsigned cycles = 0;

  // Packs the undeleted entries of one segment to its front, in order.
  function automatic void pack_shadow_segment(input int r);
    int w;
    w = 0;
    for (int i = 0; i < seg_fill[r]; i++) begin
      if (!shadow_del[r][i]) begin
        shadow_loc[r][w] = shadow_loc[r][i];
        shadow_del[r][w] = 1'b0;
        w++;
      end
    end
    seg_fill[r] = w;
    seg_dirty[r] = 1'b0;
  endfunction

  // Applies one command to the shadow list and returns the result it causes.
  function automatic list_result_t apply_list_cmd(input logic [2:0] c, input logic [63:0] l,
                                                  input logic [3:0] ri, input logic [5:0] si,
                                                  input logic ae);
    list_result_t res;
    int sz, r, s;
    bit hit;
    res = '0;
    sz = seg_size_reg;
    if (sz == 0) sz = 1;
    if (sz > SEG_SLOTS) sz = SEG_SLOTS;
    case (c)
      CMD_ADD: begin
        if (l == 64'd0) begin
          res.status = ST_INVALID;
          return res;
        end
        r = 0;
        while (r < segs_open && seg_fill[r] >= sz) r++;
        if (r >= segs_open) begin
          if (segs_open >= NUM_SEGS) begin
            res.status = ST_FULL;
            return res;
          end
          r = segs_open;
          segs_open++;
          seg_fill[r] = 0;
          seg_dirty[r] = 1'b0;
        end
        s = seg_fill[r];
        seg_fill[r]++;
        shadow_loc[r][s] = l;
        shadow_del[r][s] = 1'b0;
        res.found = 1'b1;
        res.rng = r[3:0];
        res.slot = s[5:0];
      end
      CMD_START, CMD_NEXT: begin
        if (c == CMD_NEXT) begin
          if (ae) return res;
          if (int'(ri) >= segs_open) begin
            res.status = ST_BAD_POS;
            return res;
          end
          r = ri;
          s = int'(si) + 1;
        end else begin
          r = 0;
          s = 0;
        end
        hit = 1'b0;
        while (!hit && r < segs_open) begin
          while (!hit && s < seg_fill[r]) begin
            if (!shadow_del[r][s]) hit = 1'b1;
            else s++;
          end
          if (!hit) begin
            r++;
            s = 0;
          end
        end
        if (hit) begin
          res.found = 1'b1;
          res.rng = r[3:0];
          res.slot = s[5:0];
          res.loc = shadow_loc[r][s];
        end
      end
      CMD_READ, CMD_DELETE: begin
        if (ae || int'(ri) >= segs_open || int'(si) >= seg_fill[ri]) begin
          res.status = ST_BAD_POS;
          return res;
        end
        if (c == CMD_DELETE) begin
          shadow_del[ri][si] = 1'b1;
          seg_dirty[ri] = 1'b1;
        end
        res.found = 1'b1;
        res.rng = ri;
        res.slot = si;
        res.loc = shadow_loc[ri][si];
      end
      CMD_COMPACT: begin
        for (int k = 0; k < segs_open; k++)
          if (seg_dirty[k]) pack_shadow_segment(k);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Sends one command item. It may idle first, then holds start high until
  // the item is taken. Start is left high; a drain or an idling next item lowers it.
  task automatic send_item(input logic [2:0] c, input logic [63:0] l, input logic [3:0] ri,
                           input logic [5:0] si, input logic ae);
    int gap;
    list_result_t res;
    if (gaps_enabled && $urandom_range(99) < 32) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    locator <= l;
    range_index <= ri;
    slot_index <= si;
    at_end <= ae;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    // The item was taken at this edge, so the expectation is queued now.
    res = apply_list_cmd(c, l, ri, si, ae);
    pending_results.push_back(res);
    items_sent++;
    cmd_counts[c]++;
    if (res.found) found_hits++;
    if (res.status == ST_FULL) full_hits++;
    if (res.status == ST_BAD_POS) bad_pos_hits++;
    @(negedge clk);
  endtask

  // Lowers start and waits until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the segment size register over the APB port while the block idles.
  task automatic write_seg_size(input logic [6:0] value);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_RANGE_SIZE;
    pwdata <= {25'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    seg_size_reg = value;
    @(negedge clk);
  endtask

  // Picks a position that names a stored entry when there is one; a share of
  // the time it picks an arbitrary position instead.
  task automatic pick_position(output logic [3:0] ri, output logic [5:0] si);
    int r;
    ri = 4'($urandom_range(15));
    si = 6'($urandom_range(63));
    if ($urandom_range(99) < 80) begin
      r = $urandom_range(segs_open - 1);
      if (seg_fill[r] > 0) begin
        ri = r[3:0];
        si = 6'($urandom_range(seg_fill[r] - 1));
      end
    end
  endtask

  task automatic random_locator(output logic [63:0] l);
    case ($urandom_range(19))
      0: l = 64'd0;
      1: l = '1;
      2: l = 64'd1;
      default: l = {$urandom, $urandom};
    endcase
  endtask

  // Directed corner cases at the reset segment size of 64.
  task automatic test_directed();
    send_item(CMD_START, '0, 4'd0, 6'd0, 1'b0);        // empty list
    send_item(CMD_ADD, 64'd0, 4'd0, 6'd0, 1'b0);       // invalid locator
    send_item(CMD_ADD, '1, 4'd0, 6'd0, 1'b0);
    send_item(CMD_ADD, 64'd1, 4'd0, 6'd0, 1'b0);
    send_item(CMD_ADD, 64'h8000_0000_0000_0000, 4'd0, 6'd0, 1'b0);
    send_item(CMD_READ, '0, 4'd0, 6'd0, 1'b0);
    send_item(CMD_READ, '0, 4'd0, 6'd3, 1'b0);         // slot past the fill
    send_item(CMD_READ, '0, 4'd0, 6'd0, 1'b1);         // already at end
    send_item(CMD_DELETE, '0, 4'd15, 6'd63, 1'b0);     // unopened segment
    send_item(CMD_NEXT, '0, 4'd0, 6'd0, 1'b1);
    send_item(CMD_NEXT, '0, 4'd3, 6'd0, 1'b0);         // unopened segment
    send_item(CMD_NEXT, '0, 4'd0, 6'd0, 1'b0);
    send_item(CMD_DELETE, '0, 4'd0, 6'd0, 1'b0);
    send_item(CMD_START, '0, 4'd0, 6'd0, 1'b0);        // skips the deleted one
    send_item(CMD_READ, '0, 4'd0, 6'd0, 1'b0);         // deleted entries read
    send_item(CMD_NEXT, '0, 4'd0, 6'd63, 1'b0);        // slot past fill moves on
    send_item(CMD_COMPACT, '0, 4'd0, 6'd0, 1'b0);
    send_item(CMD_READ, '0, 4'd0, 6'd0, 1'b0);
    send_item(CMD_READ, '0, 4'd0, 6'd2, 1'b0);         // now beyond the fill
    send_item(3'd6, '1, 4'd15, 6'd63, 1'b1);           // unused codes
    send_item(3'd7, '1, 4'd15, 6'd63, 1'b1);
  endtask

  // A size of zero acts as one slot, so each add opens a new segment until
  // all sixteen are open, and the remaining adds report a full list.
  task automatic test_list_full();
    write_seg_size(7'd0);
    for (int i = 0; i < 18; i++)
      send_item(CMD_ADD, {$urandom, $urandom} | 64'd1, 4'd0, 6'd0, 1'b0);
  endtask

  // Random command mix. Adds are the most common command so the segments get content.
  task automatic test_random_mix(input int count, input logic [6:0] size_val);
    logic [2:0]  c;
    logic [63:0] l;
    logic [3:0]  ri;
    logic [5:0]  si;
    logic        ae;
    int          pick;
    write_seg_size(size_val);
    for (int i = 0; i < count; i++) begin
      // A long stretch in the middle of each phase runs with no idling.
      gaps_enabled = !(i >= count / 3 && i < count / 2);
      pick = $urandom_range(99);
      if (pick < 34) c = CMD_ADD;
      else if (pick < 40) c = CMD_START;
      else if (pick < 56) c = CMD_NEXT;
      else if (pick < 72) c = CMD_READ;
      else if (pick < 90) c = CMD_DELETE;
      else if (pick < 97) c = CMD_COMPACT;
      else c = 3'($urandom_range(6, 7));
      random_locator(l);
      pick_position(ri, si);
      ae = ($urandom_range(99) < 8);
      send_item(c, l, ri, si, ae);
      // Once per phase the sender holds off until the block has answered.
      if (i == count / 2) drain_results();
    end
    gaps_enabled = 1'b1;
  endtask

  // Result monitor: compares every done strobe with the oldest expectation.
  always @(posedge clk) begin
    list_result_t want, got;
    cycles <= cycles + 1;
    if (!rst && done) begin
      got = '{status, found, result_range, result_slot, result_locator};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing expected: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected %p got %p", results_seen, want, got);
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results pending",
               cycles, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    segs_open = 1;
    seg_size_reg = 7'd64;
    foreach (seg_fill[k]) begin
      seg_fill[k] = 0;
      seg_dirty[k] = 1'b0;
    end
    foreach (cmd_counts[k]) cmd_counts[k] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_list_full();
    test_random_mix(300, 7'd64);
    test_random_mix(300, 7'd3);
    test_random_mix(280, 7'd127);
    test_random_mix(280, 7'd1);
    test_random_mix(260, 7'($urandom_range(2, 40)));
    test_random_mix(250, 7'd64);

    drain_results();
    repeat (50) @(negedge clk);

    $display("Covered %0d items: add %0d, start %0d, next %0d, read %0d, delete %0d, compact %0d.",
             items_sent, cmd_counts[CMD_ADD], cmd_counts[CMD_START], cmd_counts[CMD_NEXT],
             cmd_counts[CMD_READ], cmd_counts[CMD_DELETE], cmd_counts[CMD_COMPACT]);
    $display("Entries found %0d, full-list adds %0d, bad positions %0d, mismatches %0d.",
             found_hits, full_hits, bad_pos_hits, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
